>>> rtl/pwm_period_prescaler_calc_defines.svh
// Assertion macros used by the checker file of the prescaler calculator.
`ifndef PWM_PERIOD_PRESCALER_CALC_DEFINES_SVH
`define PWM_PERIOD_PRESCALER_CALC_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ppc_pkg.sv
// Package with types, constants and helpers of the PWM prescaler calculator.
`timescale 1ns / 1ps
package ppc_pkg;

  // Default configuration of the timer and the prescaler ladder.
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int PRESCALE_STEPS_DEF = 4;

  // Reset value of the peripheral clock register.
  localparam logic [31:0] CLOCK_HZ_RST = 32'd50000000;

  // Decimal exponent of one million.
  localparam logic [2:0] US_EXP = 3'd6;

  // Result codes.
  typedef enum logic [2:0] {
    RES_EXACT  = 3'd0,
    RES_RAISED = 3'd1,
    RES_OVF    = 3'd2,
    RES_NOFIT  = 3'd3,
    RES_ZERO   = 3'd4
  } ppc_status_t;

  // Multiplier operand selection.
  typedef enum logic [1:0] {
    MUL_BASE = 2'd0,
    MUL_QU   = 2'd1,
    MUL_QM   = 2'd2,
    MUL_DUTY = 2'd3
  } ppc_mul_op_t;

  // Divider operand selection.
  typedef enum logic [1:0] {
    DIV_Q    = 2'd0,
    DIV_PC   = 2'd1,
    DIV_DUTY = 2'd2
  } ppc_div_src_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BASE,
    ST_SINIT,
    ST_SCHK,
    ST_WCHK,
    ST_QDIV,
    ST_QWAIT,
    ST_PDIV,
    ST_PWAIT,
    ST_MUL1,
    ST_HIT,
    ST_MUL2,
    ST_FOUND,
    ST_FIT,
    ST_DMUL,
    ST_DDIV,
    ST_DWAIT,
    ST_DONE
  } ppc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_in;
    logic         zero_p;
    logic         mul_en;
    ppc_mul_op_t  mul_op;
    logic         store_base;
    logic         init_s;
    logic         dec_s;
    logic         init_w;
    logic         inc_w;
    logic         load_qpc;
    logic         dec_e;
    logic         div_start;
    ppc_div_src_t div_src;
    logic         store_qu;
    logic         store_m;
    logic         store_total;
    logic         found;
    logic         raise;
    logic         set_ovf;
    logic         load_cyc;
    logic         store_dut;
    logic         load_out;
  } ppc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_zero;
    logic base_ok;
    logic s_zero;
    logic p_ok;
    logic w_last;
    logic e_zero;
    logic div_done;
    logic rem_zero;
    logic m_zero;
    logic prod_fits;
    logic t_fits;
    logic tsel_top;
    logic out_busy;
  } ppc_sts_t;

  // Power of ten for a decimal exponent from zero to six.
  function automatic logic [31:0] pow10(input logic [2:0] e);
    logic [31:0] r;
    unique case (e)
      3'd0:    r = 32'd1;
      3'd1:    r = 32'd10;
      3'd2:    r = 32'd100;
      3'd3:    r = 32'd1000;
      3'd4:    r = 32'd10000;
      3'd5:    r = 32'd100000;
      3'd6:    r = 32'd1000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ppc_if.sv
// Channel interfaces of the PWM prescaler calculator.
`timescale 1ns / 1ps

// Request word: period, duty time and fallback select.
interface ppc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_us;
  logic [15:0] duty_us;
  logic [1:0]  fallback_prescale;
  modport source (output valid, period_us, duty_us, fallback_prescale, input ready);
  modport sink   (input valid, period_us, duty_us, fallback_prescale, output ready);
endinterface

// Result word.
interface ppc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  prescale_select;
  logic [15:0] cycle_count;
  logic [15:0] duty_count;
  modport source (output valid, status, prescale_select, cycle_count, duty_count,
                  input ready);
  modport sink   (input valid, status, prescale_select, cycle_count, duty_count,
                  output ready);
endinterface

// Configuration write word: the peripheral clock in hertz.
interface ppc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/ppc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppc_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [31:0]   rem
);

  localparam int CNW = $clog2(DW + 1);

  logic [31:0]    rem_r;
  logic [DW-1:0]  quo_r;
  logic [31:0]    dvs_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [32:0]    trial;
  logic [32:0]    diff;

  // One shift-subtract step.
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CNW'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= CNW'(DW);
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CNW'(1);
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> rtl/ppc_ctrl.sv
// Sequencer of the prescaler search, fit and duty computation.
`timescale 1ns / 1ps
module ppc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppc_pkg::ppc_sts_t sts,
  output ppc_pkg::ppc_cmd_t cmd
);

  ppc_pkg::ppc_state_t state_r;
  ppc_pkg::ppc_state_t state_nxt;
  logic                adv_e;
  logic                adv_w;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    adv_e     = 1'b0;
    adv_w     = 1'b0;
    unique case (state_r)
      ppc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ppc_pkg::ST_BASE;
        end
      end
      ppc_pkg::ST_BASE: begin
        if (sts.p_zero) begin
          cmd.zero_p = 1'b1;
          state_nxt  = ppc_pkg::ST_DONE;
        end else begin
          cmd.mul_en = 1'b1;
          cmd.mul_op = ppc_pkg::MUL_BASE;
          state_nxt  = ppc_pkg::ST_SINIT;
        end
      end
      ppc_pkg::ST_SINIT: begin
        cmd.store_base = 1'b1;
        cmd.init_s     = 1'b1;
        state_nxt      = ppc_pkg::ST_SCHK;
      end
      ppc_pkg::ST_SCHK: begin
        if (sts.base_ok) begin
          cmd.init_w = 1'b1;
          state_nxt  = ppc_pkg::ST_WCHK;
        end else if (sts.s_zero) begin
          state_nxt = ppc_pkg::ST_DONE;
        end else begin
          cmd.dec_s = 1'b1;
        end
      end
      ppc_pkg::ST_WCHK: begin
        if (sts.p_ok) begin
          cmd.load_qpc = 1'b1;
          state_nxt    = ppc_pkg::ST_QDIV;
        end else begin
          adv_w = 1'b1;
        end
      end
      ppc_pkg::ST_QDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = ppc_pkg::DIV_Q;
        state_nxt     = ppc_pkg::ST_QWAIT;
      end
      ppc_pkg::ST_QWAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.store_qu = 1'b1;
            state_nxt    = ppc_pkg::ST_PDIV;
          end else begin
            adv_e = 1'b1;
          end
        end
      end
      ppc_pkg::ST_PDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = ppc_pkg::DIV_PC;
        state_nxt     = ppc_pkg::ST_PWAIT;
      end
      ppc_pkg::ST_PWAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.store_m = 1'b1;
            state_nxt   = ppc_pkg::ST_MUL1;
          end else begin
            adv_e = 1'b1;
          end
        end
      end
      ppc_pkg::ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ppc_pkg::MUL_QU;
        state_nxt  = ppc_pkg::ST_HIT;
      end
      ppc_pkg::ST_HIT: begin
        if (sts.m_zero || sts.prod_fits) begin
          cmd.store_total = 1'b1;
          state_nxt       = ppc_pkg::ST_MUL2;
        end else begin
          adv_e = 1'b1;
        end
      end
      ppc_pkg::ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ppc_pkg::MUL_QM;
        state_nxt  = ppc_pkg::ST_FOUND;
      end
      ppc_pkg::ST_FOUND: begin
        if (!sts.m_zero && !sts.prod_fits) begin
          adv_w = 1'b1;
        end else begin
          cmd.found = 1'b1;
          state_nxt = ppc_pkg::ST_FIT;
        end
      end
      ppc_pkg::ST_FIT: begin
        if (sts.t_fits) begin
          cmd.load_cyc = 1'b1;
          state_nxt    = ppc_pkg::ST_DMUL;
        end else if (sts.tsel_top) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = ppc_pkg::ST_DONE;
        end else begin
          cmd.raise = 1'b1;
        end
      end
      ppc_pkg::ST_DMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = ppc_pkg::MUL_DUTY;
        state_nxt  = ppc_pkg::ST_DDIV;
      end
      ppc_pkg::ST_DDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = ppc_pkg::DIV_DUTY;
        state_nxt     = ppc_pkg::ST_DWAIT;
      end
      ppc_pkg::ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.store_dut = 1'b1;
          state_nxt     = ppc_pkg::ST_DONE;
        end
      end
      ppc_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ppc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppc_pkg::ST_IDLE;
      end
    endcase

    // Next decimal split, or fall through to the next period share.
    if (adv_e) begin
      if (sts.e_zero) begin
        adv_w = 1'b1;
      end else begin
        cmd.dec_e = 1'b1;
        state_nxt = ppc_pkg::ST_QDIV;
      end
    end

    // Next period share, or the next smaller prescaler, or done after the smallest.
    if (adv_w) begin
      if (sts.w_last) begin
        if (sts.s_zero) begin
          state_nxt = ppc_pkg::ST_DONE;
        end else begin
          cmd.dec_s = 1'b1;
          state_nxt = ppc_pkg::ST_SCHK;
        end
      end else begin
        cmd.inc_w = 1'b1;
        state_nxt = ppc_pkg::ST_WCHK;
      end
    end
  end

endmodule

>>> rtl/ppc_dp.sv
// Datapath: operand registers, shared multiplier, divider and result register.
`timescale 1ns / 1ps
module ppc_dp #(
  parameter int COUNT_WIDTH    = ppc_pkg::COUNT_WIDTH_DEF,
  parameter int PRESCALE_STEPS = ppc_pkg::PRESCALE_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ppc_pkg::ppc_cmd_t cmd,
  output ppc_pkg::ppc_sts_t sts,
  input  logic [31:0]       in_period_us,
  input  logic [15:0]       in_duty_us,
  input  logic [1:0]        in_fallback_prescale,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [1:0]        out_prescale_select,
  output logic [15:0]       out_cycle_count,
  output logic [15:0]       out_duty_count
);

  localparam int CW = COUNT_WIDTH;
  localparam int SW = $clog2(PRESCALE_STEPS);
  localparam int WW = $clog2(2 * PRESCALE_STEPS - 1);
  localparam int DW = (CW + 16 > 32) ? CW + 16 : 32;
  localparam logic [32:0] CMAX = (33'd1 << CW) - 33'd1;

  logic [31:0]       clk_hz_r;
  logic [31:0]       p_r;
  logic [15:0]       duty_r;
  logic [31:0]       base_r;
  logic [SW-1:0]     s_r;
  logic [WW-1:0]     w_r;
  logic [2:0]        e_r;
  logic [31:0]       clk_r;
  logic [31:0]       q_r;
  logic [31:0]       pc_r;
  logic [31:0]       qu_r;
  logic [31:0]       m_r;
  logic [31:0]       t_r;
  logic [SW-1:0]     tsel_r;
  logic [63:0]       prod_r;
  logic [2:0]        status_r;
  logic [1:0]        sel_r;
  logic [CW-1:0]     cyc_r;
  logic [CW-1:0]     dut_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [1:0]        out_sel_r;
  logic [15:0]       out_cyc_r;
  logic [15:0]       out_dut_r;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [DW-1:0]     div_dvd;
  logic [31:0]       div_dvs;
  logic              div_done;
  logic [DW-1:0]     div_quot;
  logic [31:0]       div_rem;
  logic [WW-1:0]     two_s;
  logic [WW-1:0]     sh;
  logic [31:0]       smask;
  logic [31:0]       pmask;
  logic [CW-1:0]     dq;
  logic [CW-1:0]     dut_val;

  // Shared iterative divider.
  ppc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Operand selection for the multiplier and the divider.
  always_comb begin
    unique case (cmd.mul_op)
      ppc_pkg::MUL_BASE: begin mul_a = clk_r;      mul_b = p_r;          end
      ppc_pkg::MUL_QU:   begin mul_a = qu_r;       mul_b = m_r;          end
      ppc_pkg::MUL_QM:   begin mul_a = q_r;        mul_b = m_r;          end
      default:           begin mul_a = 32'(cyc_r); mul_b = 32'(duty_r);  end
    endcase
    unique case (cmd.div_src)
      ppc_pkg::DIV_Q: begin
        div_dvd = DW'(q_r);
        div_dvs = ppc_pkg::pow10(e_r);
      end
      ppc_pkg::DIV_PC: begin
        div_dvd = DW'(pc_r);
        div_dvs = ppc_pkg::pow10(ppc_pkg::US_EXP - e_r);
      end
      default: begin
        div_dvd = prod_r[DW-1:0];
        div_dvs = p_r;
      end
    endcase
  end

  // Divisibility masks: the prescaler 4^s and the period share 2^(2s-w).
  always_comb begin
    two_s = WW'({s_r, 1'b0});
    sh    = two_s - w_r;
    smask = (32'd1 << two_s) - 32'd1;
    pmask = (32'd1 << sh) - 32'd1;
  end

  // Duty count, truncated; a quotient above the period count is clamped to one below it.
  always_comb begin
    dq      = div_quot[CW-1:0];
    dut_val = (dq > cyc_r) ? cyc_r - CW'(1) : dq;
  end

  // Status toward the controller.
  always_comb begin
    sts.p_zero    = (p_r == 32'd0);
    sts.base_ok   = ((base_r & smask) == 32'd0);
    sts.s_zero    = (s_r == '0);
    sts.p_ok      = ((p_r & pmask) == 32'd0);
    sts.w_last    = (w_r == two_s);
    sts.e_zero    = (e_r == 3'd0);
    sts.div_done  = div_done;
    sts.rem_zero  = (div_rem == 32'd0);
    sts.m_zero    = (m_r == 32'd0);
    sts.prod_fits = (prod_r[63:32] == 32'd0);
    sts.t_fits    = ({1'b0, t_r} <= CMAX);
    sts.tsel_top  = (tsel_r == SW'(PRESCALE_STEPS - 1));
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // Clock frequency register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= ppc_pkg::CLOCK_HZ_RST;
    end else if (cfg_valid) begin
      clk_hz_r <= cfg_data;
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p_r      <= in_period_us;
      duty_r   <= in_duty_us;
      clk_r    <= clk_hz_r;
      status_r <= ppc_pkg::RES_NOFIT;
      sel_r    <= in_fallback_prescale;
      cyc_r    <= '0;
      dut_r    <= '0;
    end
    if (cmd.zero_p) begin
      status_r <= ppc_pkg::RES_ZERO;
    end
    if (cmd.mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.store_base) begin
      base_r <= prod_r[31:0];
    end
    if (cmd.init_s) begin
      s_r <= SW'(PRESCALE_STEPS - 1);
    end else if (cmd.dec_s) begin
      s_r <= s_r - SW'(1);
    end
    if (cmd.init_w) begin
      w_r <= '0;
    end else if (cmd.inc_w) begin
      w_r <= w_r + WW'(1);
    end
    if (cmd.load_qpc) begin
      q_r  <= p_r >> sh;
      pc_r <= clk_r >> w_r;
      e_r  <= ppc_pkg::US_EXP;
    end else if (cmd.dec_e) begin
      e_r <= e_r - 3'd1;
    end
    if (cmd.store_qu) begin
      qu_r <= div_quot[31:0];
    end
    if (cmd.store_m) begin
      m_r <= div_quot[31:0];
    end
    if (cmd.store_total) begin
      t_r <= prod_r[31:0];
    end else if (cmd.raise) begin
      t_r <= t_r >> 2;
    end
    if (cmd.found) begin
      sel_r    <= 2'(s_r);
      tsel_r   <= s_r;
      status_r <= ppc_pkg::RES_EXACT;
    end else if (cmd.raise) begin
      tsel_r   <= tsel_r + SW'(1);
      status_r <= ppc_pkg::RES_RAISED;
    end
    if (cmd.set_ovf) begin
      status_r <= ppc_pkg::RES_OVF;
    end
    if (cmd.load_cyc) begin
      cyc_r <= t_r[CW-1:0];
      sel_r <= 2'(tsel_r);
    end
    if (cmd.store_dut) begin
      dut_r <= dut_val;
    end
  end

  // Output register, parting the result from the next search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_sel_r    <= sel_r;
      out_cyc_r    <= 16'(cyc_r);
      out_dut_r    <= 16'(dut_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_prescale_select = out_sel_r;
  assign out_cycle_count     = out_cyc_r;
  assign out_duty_count      = out_dut_r;

endmodule

>>> rtl/pwm_period_prescaler_calc.sv
// Top level of the PWM period and prescaler calculator.
`timescale 1ns / 1ps
// Converts a period in microseconds and a high time into a clock divide select,
// a period count and a duty count, against the peripheral clock written on the
// configuration channel. One request word is worked on at a time. The search
// over prescaler, period share and decimal split runs through one shared
// radix-2 divider (DW = max(32, COUNT_WIDTH+16) bits), with one or two divisions
// for each decimal split tried, and a duty division once a word fits. The worst
// case (no fit at all) tries 16 period shares with 7 splits each by default. A
// zero period is answered without a search. The result sits in an output
// register, so a new request word is taken while the previous result waits.
module pwm_period_prescaler_calc #(
  parameter int COUNT_WIDTH    = ppc_pkg::COUNT_WIDTH_DEF,
  parameter int PRESCALE_STEPS = ppc_pkg::PRESCALE_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ppc_in_if.sink    in_ch,
  ppc_out_if.source out_ch,
  ppc_cfg_if.sink   cfg_ch
);

  ppc_pkg::ppc_cmd_t cmd;
  ppc_pkg::ppc_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Sequencer.
  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  ppc_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PRESCALE_STEPS (PRESCALE_STEPS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_period_us         (in_ch.period_us),
    .in_duty_us           (in_ch.duty_us),
    .in_fallback_prescale (in_ch.fallback_prescale),
    .cfg_valid            (cfg_ch.valid),
    .cfg_data             (cfg_ch.data),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_prescale_select  (out_ch.prescale_select),
    .out_cycle_count      (out_ch.cycle_count),
    .out_duty_count       (out_ch.duty_count)
  );

endmodule

>>> rtl/ppc_check.sv
// Port-level assertions of the prescaler calculator and their bind.
`timescale 1ns / 1ps
`include "pwm_period_prescaler_calc_defines.svh"
module ppc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [1:0]  prescale_select,
  input logic [15:0] cycle_count,
  input logic [15:0] duty_count
);

  // A stalled result word holds.
  `PPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(prescale_select) &&
    $stable(cycle_count) && $stable(duty_count),
    "stalled result changed")

  // Only defined result codes leave the block.
  `PPC_ASSERT_NOW(a_status_code, out_valid, status <= ppc_pkg::RES_ZERO, "undefined result code")

  // Overflow, no fit and zero period carry zero counts.
  `PPC_ASSERT_NOW(a_zero_counts,
    out_valid && (status == ppc_pkg::RES_OVF || status == ppc_pkg::RES_NOFIT ||
    status == ppc_pkg::RES_ZERO),
    cycle_count == 16'd0 && duty_count == 16'd0,
    "failed result with nonzero counts")

  // A taken request word keeps the input closed in the next cycle.
  `PPC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "input open right after a request")

endmodule

bind pwm_period_prescaler_calc ppc_check u_ppc_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .prescale_select (out_ch.prescale_select),
  .cycle_count     (out_ch.cycle_count),
  .duty_count      (out_ch.duty_count)
);
